>>> design/omf_record_deframer_macros.svh
// assertion macros used by the deframer module
`ifndef OMF_RECORD_DEFRAMER_MACROS_SVH
`define OMF_RECORD_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define OMFRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OMFRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/omfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package omfrd_pkg;

   // parser phase, one-hot
   typedef enum logic [7:0] {
      PH_TYPE   = 8'b0000_0001,
      PH_LEN_LO = 8'b0000_0010,
      PH_LEN_HI = 8'b0000_0100,
      PH_DATA   = 8'b0000_1000,
      PH_CHECK  = 8'b0001_0000,
      PH_ENDED  = 8'b0010_0000,
      PH_CLOSED = 8'b0100_0000,
      PH_HALTED = 8'b1000_0000
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_ZERO_LEN    = 3'd1;
   localparam logic [2:0] ST_OVERSIZE    = 3'd2;
   localparam logic [2:0] ST_CHECKSUM    = 3'd3;
   localparam logic [2:0] ST_TRUNCATED   = 3'd4;
   localparam logic [2:0] ST_NO_HEADER   = 3'd5;
   localparam logic [2:0] ST_NO_END      = 3'd6;

   // record types of interest
   localparam logic [7:0] TYPE_HEADER = 8'h80;
   localparam logic [7:0] TYPE_END    = 8'h8A;

   // result field widths
   localparam int unsigned OFS_W  = 10;
   localparam int unsigned PLEN_W = 11;

endpackage

`default_nettype wire

>>> design/omf_record_deframer.sv
// a result is registered, valid in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle while req_tready is high, set by the single phase update and 8-bit sum
// a held result is parted from the input by the result register, so input flows
// on while rsp_tready is high or the register is empty
// reset: synchronous, clears phase, counters, sum and result valid
`timescale 1ns / 1ps
`default_nettype none

`include "omf_record_deframer_macros.svh"

module omf_record_deframer
   import omfrd_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,   // [0] end_of_input
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] record_type, [15:8] payload_byte,
                                         // [25:16] byte_offset, [36:26] payload_length,
                                         // [39:37] status
   output logic [1:0]       rsp_tuser    // [1:0] kind
);

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

   // parser state
   phase_type           phase_ff, phase_in;
   logic [7:0]          current_type_ff, current_type_in;
   logic [15:0]         declared_length_ff, declared_length_in;
   logic [CNT_W-1:0]    payload_count_ff, payload_count_in;
   logic [7:0]          running_sum_ff, running_sum_in;
   logic                first_seen_ff, first_seen_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          rtype_ff, rtype_in;
   logic [7:0]          pbyte_ff, pbyte_in;
   logic [OFS_W-1:0]    ofs_ff, ofs_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [2:0]          status_ff, status_in;

   logic                accept;
   logic                emit;
   logic [7:0]          in_byte;
   logic                in_eoi;
   logic [7:0]          sum_add;
   logic [15:0]         len_hi_value;
   logic [15:0]         len_m1_hi;
   logic [15:0]         len_m1;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign in_byte    = req_tdata;
   assign in_eoi     = req_tuser[0];

   assign sum_add      = running_sum_ff + in_byte;
   assign len_hi_value = {in_byte, declared_length_ff[7:0]};
   assign len_m1_hi    = len_hi_value - 16'd1;
   assign len_m1       = declared_length_ff - 16'd1;

   // phase update and result selection for one accepted item
   always_comb begin
      phase_in           = phase_ff;
      current_type_in    = current_type_ff;
      declared_length_in = declared_length_ff;
      payload_count_in   = payload_count_ff;
      running_sum_in     = running_sum_ff;
      first_seen_in      = first_seen_ff;
      emit               = 1'b0;
      kind_in            = KIND_PAYLOAD;
      pbyte_in           = 8'd0;
      ofs_in             = '0;
      plen_in            = '0;
      status_in          = ST_OK;

      if (accept) begin
         case (phase_ff)
            PH_TYPE, PH_LEN_LO, PH_LEN_HI: begin
               if (in_eoi) begin
                  emit = 1'b1;
                  if (!first_seen_ff) begin
                     kind_in   = KIND_ERROR;
                     status_in = ST_NO_HEADER;
                     phase_in  = PH_HALTED;
                  end else begin
                     kind_in   = KIND_END;
                     status_in = ST_NO_END;
                     phase_in  = PH_CLOSED;
                  end
               end else if (phase_ff == PH_TYPE) begin
                  current_type_in    = in_byte;
                  running_sum_in     = in_byte;
                  declared_length_in = 16'd0;
                  payload_count_in   = '0;
                  phase_in           = PH_LEN_LO;
               end else if (phase_ff == PH_LEN_LO) begin
                  declared_length_in = {8'h00, in_byte};
                  running_sum_in     = sum_add;
                  phase_in           = PH_LEN_HI;
               end else begin
                  declared_length_in = len_hi_value;
                  running_sum_in     = sum_add;
                  if (len_hi_value == 16'd0) begin
                     emit      = 1'b1;
                     kind_in   = KIND_ERROR;
                     status_in = ST_ZERO_LEN;
                     phase_in  = PH_HALTED;
                  end else if ({1'b0, len_m1_hi} > 17'(MAX_PAYLOAD)) begin
                     emit      = 1'b1;
                     kind_in   = KIND_ERROR;
                     status_in = ST_OVERSIZE;
                     phase_in  = PH_HALTED;
                  end else begin
                     phase_in = (len_hi_value == 16'd1) ? PH_CHECK : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               emit = 1'b1;
               if (in_eoi) begin
                  kind_in   = KIND_ERROR;
                  status_in = ST_TRUNCATED;
                  phase_in  = PH_HALTED;
               end else begin
                  running_sum_in   = sum_add;
                  payload_count_in = payload_count_ff + 1'b1;
                  kind_in          = KIND_PAYLOAD;
                  pbyte_in         = in_byte;
                  ofs_in           = OFS_W'(payload_count_ff);
                  if (16'(payload_count_in) >= len_m1) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_CHECK: begin
               emit = 1'b1;
               if (in_eoi) begin
                  kind_in   = KIND_ERROR;
                  status_in = ST_TRUNCATED;
                  phase_in  = PH_HALTED;
               end else if (in_byte != 8'd0 && sum_add != 8'd0) begin
                  kind_in   = KIND_ERROR;
                  status_in = ST_CHECKSUM;
                  phase_in  = PH_HALTED;
               end else begin
                  first_seen_in = 1'b1;
                  if (!first_seen_ff && current_type_ff != TYPE_HEADER) begin
                     kind_in   = KIND_ERROR;
                     status_in = ST_NO_HEADER;
                     phase_in  = PH_HALTED;
                  end else begin
                     kind_in  = KIND_DONE;
                     plen_in  = PLEN_W'(len_m1);
                     phase_in = (first_seen_ff && current_type_ff == TYPE_END) ?
                                PH_ENDED : PH_TYPE;
                  end
               end
            end
            PH_ENDED: begin
               // data after the end record is dropped
               if (in_eoi) begin
                  emit      = 1'b1;
                  kind_in   = KIND_END;
                  status_in = ST_OK;
                  phase_in  = PH_CLOSED;
               end
            end
            default: begin
               // closed or halted: items are taken and dropped
            end
         endcase
      end
   end

   assign rtype_in     = current_type_ff;
   assign rsp_valid_in = req_tready ? emit : rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_TYPE;
         current_type_ff    <= 8'd0;
         declared_length_ff <= 16'd0;
         payload_count_ff   <= '0;
         running_sum_ff     <= 8'd0;
         first_seen_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         current_type_ff    <= current_type_in;
         declared_length_ff <= declared_length_in;
         payload_count_ff   <= payload_count_in;
         running_sum_ff     <= running_sum_in;
         first_seen_ff      <= first_seen_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // result payload, loaded whenever the register is free
   always_ff @(posedge clock) begin
      if (req_tready) begin
         kind_ff   <= kind_in;
         rtype_ff  <= rtype_in;
         pbyte_ff  <= pbyte_in;
         ofs_ff    <= ofs_in;
         plen_ff   <= plen_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {status_ff, plen_ff, ofs_ff, pbyte_ff, rtype_ff};

   // checks
   `OMFRD_ASSERT_NOW(a_phase_onehot, clock, reset, 1'b1, $onehot(phase_ff),
      "phase register lost its one-hot code")
   `OMFRD_ASSERT_NEXT(a_halt_sticky, clock, reset, phase_ff == PH_HALTED,
      phase_ff == PH_HALTED, "left halted state without reset")
   `OMFRD_ASSERT_NEXT(a_no_result_when_halted, clock, reset,
      (phase_ff == PH_HALTED || phase_ff == PH_CLOSED) && !rsp_valid_ff,
      !rsp_valid_ff, "result produced after halt or close")

endmodule

`default_nettype wire
